@@ sv/audio_sample_queue_drop_oldest_top_macros.svh @@
// Assertion helpers for the sample queue checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef AUDIO_SAMPLE_QUEUE_DROP_OLDEST_TOP_MACROS_SVH
`define AUDIO_SAMPLE_QUEUE_DROP_OLDEST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASQDO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASQDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/asqdo_pkg.sv @@
package asqdo_pkg;

  // Default sizes of the sample store and of one read burst.
  localparam int DEPTH_DEF    = 4096;
  localparam int MAX_READ_DEF = 64;

  // Quotient bits resolved per cycle by the channel divider.
  localparam int DIV_BITS = 4;

  // Field and register widths.
  localparam int CMD_W      = 2;
  localparam int SMP_W      = 16;
  localparam int FWANT_W    = 4;
  localparam int QF_W       = 13;
  localparam int CH_W       = 4;
  localparam int LF_W       = 13;
  localparam int BB_W       = 16;
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_FRAMES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_BYTES = 2'd2;

  // Register values after reset.
  localparam logic [CH_W-1:0] CH_RESET = 4'd2;
  localparam logic [LF_W-1:0] LF_RESET = 13'd0;
  localparam logic [BB_W-1:0] BB_RESET = 16'd1024;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SMP_W-1:0] sample_in;
    logic [FWANT_W-1:0]      frames_wanted;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    sample_valid;
    logic                    last;
    logic [QF_W-1:0]         queued_frames;
    logic                    dropped;
  } out_item_t;

endpackage

@@ sv/audio_sample_queue_drop_oldest_top.sv @@
// Interleaved 16-bit audio sample queue with a latency cap. A push request
// appends one sample; when the queue then holds more than its limit
// (limit_frames * channels, or 3 * buffer_bytes / 2 when limit_frames is
// zero, never more than DEPTH) the oldest samples are discarded in whole
// frames and the single result carries dropped = 1. A read request returns
// up to frames_wanted frames (whole frames within MAX_READ samples) as a run
// of results with last set on the final one; an empty queue gives one result
// with sample_valid low. A clear request empties the queue. Every result
// reports queued_frames after it. Samples live in one DEPTH x 16 memory with
// a registered read port. A push runs the limit check, then, when it trims,
// the shared 4-bit-per-cycle divider that rounds the excess to whole frames,
// then the trim and the store write; no new request is taken until its
// result is loaded. A read streams one sample per cycle from the memory port
// while the output is not stalled. A write of the channels register stalls
// input for that same divider run while the frame count is recomputed.
module audio_sample_queue_drop_oldest_top #(
  parameter int DEPTH    = asqdo_pkg::DEPTH_DEF,
  parameter int MAX_READ = asqdo_pkg::MAX_READ_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [asqdo_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [asqdo_pkg::REG_DATA_W-1:0] wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  asqdo_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output asqdo_pkg::out_item_t             out_data
);
  import asqdo_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int FW      = $clog2(DEPTH + 1);
  localparam int CW      = $clog2(DEPTH + 2);
  localparam int RW      = $clog2(MAX_READ + 1);
  localparam int TW      = FW + 8;
  localparam int LW      = 18;
  localparam int DIV_CYC = (CW + DIV_BITS - 1) / DIV_BITS;
  localparam int DVW     = DIV_BITS * DIV_CYC;
  localparam int DCW     = $clog2(DIV_CYC + 1);

  // Largest whole-frame burst per channel count; a burst that fits no frame
  // falls back to MAX_READ samples.
  localparam int CAP_TAB [16] = '{
    MAX_READ,
    (MAX_READ / 1) * 1,
    (MAX_READ / 2) * 2,
    (MAX_READ / 3) * 3,
    (MAX_READ / 4) * 4,
    (MAX_READ / 5) * 5,
    (MAX_READ / 6) * 6,
    (MAX_READ / 7) * 7,
    (MAX_READ / 8) * 8,
    ((MAX_READ / 9) == 0) ? MAX_READ : (MAX_READ / 9) * 9,
    ((MAX_READ / 10) == 0) ? MAX_READ : (MAX_READ / 10) * 10,
    ((MAX_READ / 11) == 0) ? MAX_READ : (MAX_READ / 11) * 11,
    ((MAX_READ / 12) == 0) ? MAX_READ : (MAX_READ / 12) * 12,
    ((MAX_READ / 13) == 0) ? MAX_READ : (MAX_READ / 13) * 13,
    ((MAX_READ / 14) == 0) ? MAX_READ : (MAX_READ / 14) * 14,
    ((MAX_READ / 15) == 0) ? MAX_READ : (MAX_READ / 15) * 15
  };

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LIM   = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_DROP  = 9'b000001000,
    S_FIN   = 9'b000010000,
    S_ONE   = 9'b000100000,
    S_RDSET = 9'b001000000,
    S_READ  = 9'b010000000,
    S_REDIV = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [CH_W-1:0] channels;
  logic [LF_W-1:0] limit_frames;
  logic [BB_W-1:0] buffer_bytes;
  logic [CH_W-1:0] ch_eff;
  logic            cfg_ch_wr;

  // Queue state: head pointer, sample count and the count split into
  // whole frames and leftover samples.
  logic [AW-1:0]   head;
  logic [FW-1:0]   fill;
  logic [FW-1:0]   q;
  logic [CH_W-1:0] rem;

  // Request and push working registers.
  logic [SMP_W-1:0]   smp_r;
  logic [FWANT_W-1:0] fw_r;
  logic               drop_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      ex_r;
  logic [AW-1:0]      tail_r;
  logic [CW-1:0]      d_r;
  logic [CW-1:0]      k_r;

  // Divider.
  logic [DVW-1:0]  div_q;
  logic [CH_W-1:0] div_r;
  logic [DCW-1:0]  div_cnt;
  logic [DVW-1:0]  div_pq;
  logic [CH_W:0]   div_pr;

  // Read burst.
  logic [RW-1:0]    remn;
  logic             pend;
  logic             pend_last;
  logic [QF_W-1:0]  pend_qf;
  logic [SMP_W-1:0] rd_data;
  logic             rd_issue;
  logic             pend_move;
  logic             out_free;
  logic             one_load;
  logic [RW-1:0]    rd_cnt;
  logic [RW-1:0]    cap;
  logic [7:0]       fw_ch;
  logic [TW-1:0]    cnt_a;
  logic [TW-1:0]    cnt_b;

  // Limit and trim arithmetic.
  logic [LW-1:0] lim_prod;
  logic [LW-1:0] lim_dflt;
  logic [LW-1:0] lim_raw;
  logic [FW-1:0] lim_val;
  logic [CW-1:0] lim_n;
  logic [CW-1:0] drop_d0;
  logic          drop_over;
  logic [CW:0]   drop_d1;
  logic [CW-1:0] drop_d;
  logic [CW-1:0] drop_k;
  logic          mem_we;

  logic [SMP_W-1:0] mem [DEPTH];

  function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
    logic [AW:0] y;
    y = (x >= (AW+1)'(DEPTH)) ? x - (AW+1)'(DEPTH) : x;
    return y[AW-1:0];
  endfunction

  assign ch_eff    = (channels == '0) ? CH_W'(1) : channels;
  assign cfg_ch_wr = wr_en && (wr_index == REG_CHANNELS);
  assign in_stall  = (state != S_IDLE) || cfg_ch_wr;
  assign out_free  = !out_valid || !out_stall;
  assign one_load  = (state == S_ONE) && out_free;
  assign pend_move = (state == S_READ) && pend && out_free;
  assign rd_issue  = (state == S_READ) && (remn != '0) && (!pend || pend_move);
  assign mem_we    = (state == S_FIN) && (d_r <= CW'(fill));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      channels     <= CH_RESET;
      limit_frames <= LF_RESET;
      buffer_bytes <= BB_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNELS:     channels     <= wr_data[CH_W-1:0];
        REG_LIMIT_FRAMES: limit_frames <= wr_data[LF_W-1:0];
        REG_BUFFER_BYTES: buffer_bytes <= wr_data[BB_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider step: DIV_BITS restoring steps on the channel count.
  always_comb begin
    div_pr = {1'b0, div_r};
    div_pq = div_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_pr = {div_pr[CH_W-1:0], div_pq[DVW-1]};
      div_pq = {div_pq[DVW-2:0], 1'b0};
      if (div_pr >= {1'b0, ch_eff}) begin
        div_pr    = div_pr - {1'b0, ch_eff};
        div_pq[0] = 1'b1;
      end
    end
  end

  // Queue limit in samples and the count after a push.
  always_comb begin
    lim_prod = LW'({4'd0, limit_frames} * {13'd0, ch_eff});
    lim_dflt = ({2'd0, buffer_bytes} + {1'b0, buffer_bytes, 1'b0}) >> 1;
    lim_raw  = (limit_frames != '0) ? lim_prod : lim_dflt;
    lim_val  = (lim_raw > LW'(DEPTH)) ? FW'(DEPTH) : lim_raw[FW-1:0];
    lim_n    = CW'(fill) + CW'(1);
  end

  // Excess rounded to whole frames, one more frame if the store would
  // overflow, and never more than the queue holds with the new sample.
  always_comb begin
    drop_d0   = ex_r - CW'(div_r);
    drop_over = (n_r - drop_d0) > CW'(DEPTH);
    drop_d1   = {1'b0, drop_d0} + (drop_over ? (CW+1)'(ch_eff) : '0);
    drop_k    = div_q[CW-1:0] + CW'(drop_over);
    drop_d    = (drop_d1 > {1'b0, n_r}) ? n_r : drop_d1[CW-1:0];
  end

  // Burst length for a read request.
  always_comb begin
    cap   = RW'(CAP_TAB[ch_eff]);
    fw_ch = {4'd0, fw_r} * {4'd0, ch_eff};
    cnt_a = ((fw_r != '0) && (TW'(fill) > TW'(fw_ch))) ? TW'(fw_ch) : TW'(fill);
    cnt_b = (cnt_a > TW'(cap)) ? TW'(cap) : cnt_a;
    rd_cnt = cnt_b[RW-1:0];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_ch_wr) begin
          state_next = S_REDIV;
        end else if (in_valid) begin
          case (in_data.cmd)
            CMD_PUSH: state_next = S_LIM;
            CMD_READ: state_next = S_RDSET;
            default:  state_next = S_ONE;
          endcase
        end
      end
      S_LIM:   state_next = (lim_n > CW'(lim_val)) ? S_DIV : S_DROP;
      S_DIV:   if (div_cnt == DCW'(1)) state_next = S_DROP;
      S_DROP:  state_next = S_FIN;
      S_FIN:   state_next = S_ONE;
      S_ONE:   if (out_free) state_next = S_IDLE;
      S_RDSET: state_next = (rd_cnt == '0) ? S_ONE : S_READ;
      S_READ:  if ((remn == '0) && (!pend || pend_move)) state_next = S_IDLE;
      S_REDIV: begin
        if (cfg_ch_wr) begin
          state_next = S_REDIV;
        end else if (div_cnt == DCW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Queue state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      fill    <= '0;
      q       <= '0;
      rem     <= '0;
      drop_r  <= 1'b0;
      remn    <= '0;
      pend    <= 1'b0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cfg_ch_wr) begin
            div_q   <= DVW'(fill);
            div_r   <= '0;
            div_cnt <= DCW'(DIV_CYC);
          end else if (in_valid) begin
            smp_r  <= in_data.sample_in;
            fw_r   <= in_data.frames_wanted;
            drop_r <= 1'b0;
            if (in_data.cmd == CMD_CLEAR) begin
              fill <= '0;
              q    <= '0;
              rem  <= '0;
            end
          end
        end
        S_LIM: begin
          n_r    <= lim_n;
          tail_r <= wrap({1'b0, head} + (AW+1)'(fill));
          if (lim_n > CW'(lim_val)) begin
            ex_r  <= lim_n - CW'(lim_val);
            div_q <= DVW'(lim_n - CW'(lim_val));
          end else begin
            ex_r  <= '0;
            div_q <= '0;
          end
          div_r   <= '0;
          div_cnt <= DCW'(DIV_CYC);
          // Frame count of the queue with the new sample added.
          if ((rem + CH_W'(1)) == ch_eff) begin
            rem <= '0;
            q   <= q + FW'(1);
          end else begin
            rem <= rem + CH_W'(1);
          end
        end
        S_DIV, S_REDIV: begin
          if ((state == S_REDIV) && cfg_ch_wr) begin
            div_q   <= DVW'(fill);
            div_r   <= '0;
            div_cnt <= DCW'(DIV_CYC);
          end else begin
            div_q   <= div_pq;
            div_r   <= div_pr[CH_W-1:0];
            div_cnt <= div_cnt - DCW'(1);
            if ((state == S_REDIV) && (div_cnt == DCW'(1))) begin
              q   <= div_pq[FW-1:0];
              rem <= div_pr[CH_W-1:0];
            end
          end
        end
        S_DROP: begin
          d_r <= drop_d;
          k_r <= drop_k;
        end
        S_FIN: begin
          drop_r <= (d_r != '0);
          if (d_r <= CW'(fill)) begin
            head <= wrap({1'b0, head} + (AW+1)'(d_r));
            fill <= FW'(n_r - d_r);
            q    <= q - FW'(k_r);
          end else begin
            // The trim swallows every sample, the new one included.
            head <= tail_r;
            fill <= '0;
            q    <= '0;
            rem  <= '0;
          end
        end
        S_RDSET: begin
          remn <= rd_cnt;
        end
        S_READ: begin
          if (rd_issue) begin
            head      <= wrap({1'b0, head} + (AW+1)'(1));
            fill      <= fill - FW'(1);
            remn      <= remn - RW'(1);
            pend_last <= (remn == RW'(1));
            if (rem == '0) begin
              rem     <= ch_eff - CH_W'(1);
              q       <= q - FW'(1);
              pend_qf <= QF_W'(q - FW'(1));
            end else begin
              rem     <= rem - CH_W'(1);
              pend_qf <= QF_W'(q);
            end
          end
          if (rd_issue) begin
            pend <= 1'b1;
          end else if (pend_move) begin
            pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample store: write on a kept push, read at the head on each issue.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= smp_r;
    end
    if (rd_issue) begin
      rd_data <= mem[head];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (one_load || pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (one_load) begin
      out_data.sample_out    <= '0;
      out_data.sample_valid  <= 1'b0;
      out_data.last          <= 1'b1;
      out_data.queued_frames <= QF_W'(q);
      out_data.dropped       <= drop_r;
    end else if (pend_move) begin
      out_data.sample_out    <= rd_data;
      out_data.sample_valid  <= 1'b1;
      out_data.last          <= pend_last;
      out_data.queued_frames <= pend_qf;
      out_data.dropped       <= 1'b0;
    end
  end

endmodule

@@ sv/asqdo_checker.sv @@
`include "audio_sample_queue_drop_oldest_top_macros.svh"

module asqdo_checker #(
  parameter int DEPTH = asqdo_pkg::DEPTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input asqdo_pkg::out_item_t out_data
);

  // A stalled result stays offered unchanged.
  `ASQDO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Results without a sample carry zero and close their request.
  `ASQDO_ASSERT_NOW(a_empty_result, out_valid && !out_data.sample_valid, (out_data.sample_out == '0) && out_data.last, "result without sample malformed")

  // Only a push result can report discarded samples.
  `ASQDO_ASSERT_NOW(a_drop_on_push, out_valid && out_data.dropped, !out_data.sample_valid, "dropped set on a read sample")

  // The queue never reports more frames than the store holds.
  `ASQDO_ASSERT_NOW(a_frames_bound, out_valid, 32'(out_data.queued_frames) <= 32'(DEPTH), "queued_frames beyond store depth")

endmodule

bind audio_sample_queue_drop_oldest_top asqdo_checker #(.DEPTH(DEPTH)) u_asqdo_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
